// ===== sv/lbmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbmc_pkg
// Shared widths, constants, payload types and fixed-point helpers for the
// D2Q9 BGK node collision core.
// ----------------------------------------------------------------------------
package lbmc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int NDIR        = 9;
    localparam int RATE_WIDTH  = 30;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 4;
    localparam int MOM_WIDTH   = VALUE_WIDTH + 3;
    localparam int CU_WIDTH    = VALUE_WIDTH + 2;
    localparam int POLY_WIDTH  = VALUE_WIDTH + 6;
    localparam int PROD_WIDTH  = 2 * VALUE_WIDTH + 2;
    localparam int DIV_STEPS   = VALUE_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0]           val_t;
    typedef logic signed [NDIR-1:0][VALUE_WIDTH-1:0] dist_t;
    typedef logic [RATE_WIDTH-1:0]                   rate_t;
    typedef logic [PROD_WIDTH-1:0]                   prod_t;

    localparam val_t VAL_MAX = val_t'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam val_t VAL_MIN = val_t'({1'b1, {(VALUE_WIDTH-1){1'b0}}});

    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    localparam rate_t RATE_RESET = rate_t'((ONE_L * 10 + 4) / 9);
    localparam val_t  W_REST     = val_t'((ONE_L * 4 + 4) / 9);
    localparam val_t  W_AXIS     = val_t'((ONE_L + 4) / 9);
    localparam val_t  W_DIAG     = val_t'((ONE_L + 18) / 36);

    localparam logic signed [POLY_WIDTH-1:0] POLY_BIAS = POLY_WIDTH'(2 * ONE_L);

    typedef struct packed {
        dist_t f;
        val_t  rho;
    } side_t;

    typedef struct packed {
        logic signed [MOM_WIDTH-1:0] mx;
        logic signed [MOM_WIDTH-1:0] my;
        side_t                       side;
    } front_t;

    typedef struct packed {
        val_t  ux;
        val_t  uy;
        side_t side;
    } vel_t;

    typedef struct packed {
        dist_t f;
        val_t  rho;
        val_t  ux;
        val_t  uy;
    } result_t;

    function automatic val_t sat_wide(input logic signed [PROD_WIDTH-1:0] v);
        val_t r;
        if (v > PROD_WIDTH'(VAL_MAX))
            r = VAL_MAX;
        else if (v < PROD_WIDTH'(VAL_MIN))
            r = VAL_MIN;
        else
            r = v[VALUE_WIDTH-1:0];
        return r;
    endfunction

    // round to nearest, ties away from zero, of a magnitude product, then limit
    function automatic val_t round_mag(input prod_t p, input logic neg);
        prod_t q;
        prod_t lim;
        q   = (p + (prod_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = neg ? prod_t'(VAL_MAX) + prod_t'(1) : prod_t'(VAL_MAX);
        if (q > lim)
            q = lim;
        return neg ? val_t'(-q) : val_t'(q);
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] mag_val(input val_t v);
        return v[VALUE_WIDTH-1] ? VALUE_WIDTH'(-v) : VALUE_WIDTH'(v);
    endfunction

    function automatic logic [CU_WIDTH-1:0] mag_cu(input logic signed [CU_WIDTH-1:0] v);
        return v[CU_WIDTH-1] ? CU_WIDTH'(-v) : CU_WIDTH'(v);
    endfunction

endpackage

// ===== sv/lbmc_if.sv =====
// ----------------------------------------------------------------------------
// lbmc_if
// Valid/ready channels of the collision core: node input, result output and
// relaxation-rate configuration write.
// ----------------------------------------------------------------------------
interface lbmc_node_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_0;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_1;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_2;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_3;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_4;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_5;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_6;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_7;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_in_8;

    modport source (
        output valid, dist_in_0, dist_in_1, dist_in_2, dist_in_3, dist_in_4,
               dist_in_5, dist_in_6, dist_in_7, dist_in_8,
        input  ready
    );
    modport sink (
        input  valid, dist_in_0, dist_in_1, dist_in_2, dist_in_3, dist_in_4,
               dist_in_5, dist_in_6, dist_in_7, dist_in_8,
        output ready
    );
endinterface

interface lbmc_result_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_0;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_1;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_2;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_3;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_4;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_5;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_6;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_7;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   dist_out_8;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   density;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   velocity_x;
    logic signed [lbmc_pkg::VALUE_WIDTH-1:0]   velocity_y;

    modport source (
        output valid, dist_out_0, dist_out_1, dist_out_2, dist_out_3, dist_out_4,
               dist_out_5, dist_out_6, dist_out_7, dist_out_8,
               density, velocity_x, velocity_y,
        input  ready
    );
    modport sink (
        input  valid, dist_out_0, dist_out_1, dist_out_2, dist_out_3, dist_out_4,
               dist_out_5, dist_out_6, dist_out_7, dist_out_8,
               density, velocity_x, velocity_y,
        output ready
    );
endinterface

interface lbmc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lbmc_pkg::RATE_WIDTH-1:0]     relax_rate;

    modport source (output valid, relax_rate, input ready);
    modport sink   (input valid, relax_rate, output ready);
endinterface

// ===== sv/lbmc_front.sv =====
// ----------------------------------------------------------------------------
// lbmc_front
// Input register, then density (saturated) and x/y momentum sums.
// ----------------------------------------------------------------------------
module lbmc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  lbmc_pkg::dist_t  in_dist,
    output logic             out_valid,
    output lbmc_pkg::front_t out_data
);
    import lbmc_pkg::*;

    dist_t  f_reg;
    logic   in_vld_reg;
    logic   out_vld_reg;
    front_t data_reg;
    front_t data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg  <= in_valid;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg    <= in_dist;
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        logic signed [SUM_WIDTH-1:0] sum;
        sum = '0;
        for (int k = 0; k < NDIR; k++)
            sum = sum + SUM_WIDTH'($signed(f_reg[k]));
        data_next.mx = MOM_WIDTH'($signed(f_reg[1])) + MOM_WIDTH'($signed(f_reg[5]))
                     + MOM_WIDTH'($signed(f_reg[8])) - MOM_WIDTH'($signed(f_reg[3]))
                     - MOM_WIDTH'($signed(f_reg[6])) - MOM_WIDTH'($signed(f_reg[7]));
        data_next.my = MOM_WIDTH'($signed(f_reg[2])) + MOM_WIDTH'($signed(f_reg[5]))
                     + MOM_WIDTH'($signed(f_reg[6])) - MOM_WIDTH'($signed(f_reg[4]))
                     - MOM_WIDTH'($signed(f_reg[7])) - MOM_WIDTH'($signed(f_reg[8]));
        data_next.side.f   = f_reg;
        data_next.side.rho = sat_wide(PROD_WIDTH'(sum));
    end

    assign out_valid = out_vld_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/lbmc_div.sv =====
// ----------------------------------------------------------------------------
// lbmc_div
// Pipelined restoring divider, two lanes: u = round(m * ONE / rho), one
// quotient bit per stage, saturated; zero when rho is not positive.
// ----------------------------------------------------------------------------
module lbmc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  lbmc_pkg::front_t in_data,
    output logic             out_valid,
    output lbmc_pkg::vel_t   out_data
);
    import lbmc_pkg::*;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0] quo;
        logic [VALUE_WIDTH-1:0] bits;
        logic                   neg;
        logic                   over;
    } dlane_t;

    typedef struct packed {
        dlane_t [1:0]           lane;
        logic [VALUE_WIDTH-2:0] dvs;
        logic                   pos;
        side_t                  side;
    } dstage_t;

    function automatic dstage_t div_step(input dstage_t s);
        dstage_t                o;
        logic [VALUE_WIDTH-1:0] r2;
        logic [VALUE_WIDTH-1:0] dz;
        o  = s;
        dz = {1'b0, s.dvs};
        for (int l = 0; l < 2; l++)
        begin
            r2 = {s.lane[l].rem[VALUE_WIDTH-2:0], s.lane[l].bits[VALUE_WIDTH-1]};
            o.lane[l].bits = s.lane[l].bits << 1;
            if (r2 >= dz)
            begin
                o.lane[l].rem = r2 - dz;
                o.lane[l].quo = {s.lane[l].quo[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                o.lane[l].rem = r2;
                o.lane[l].quo = {s.lane[l].quo[VALUE_WIDTH-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    dstage_t            st_reg [0:DIV_STEPS];
    dstage_t            st_next [0:DIV_STEPS];
    logic [DIV_STEPS+1:0] vld_reg;
    vel_t               out_reg;
    vel_t               out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DIV_STEPS:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
                st_reg[i] <= st_next[i];
            out_reg <= out_next;
        end
    end

    // operand setup: magnitude, overflow check, first partial remainder
    always_comb
    begin
        logic signed [MOM_WIDTH-1:0] m;
        logic [MOM_WIDTH-1:0]        um;
        logic [MOM_WIDTH-1:0]        hi;
        st_next[0].side = in_data.side;
        st_next[0].pos  = !in_data.side.rho[VALUE_WIDTH-1] && (in_data.side.rho != '0);
        st_next[0].dvs  = in_data.side.rho[VALUE_WIDTH-2:0];
        for (int l = 0; l < 2; l++)
        begin
            m  = (l == 0) ? in_data.mx : in_data.my;
            um = m[MOM_WIDTH-1] ? MOM_WIDTH'(-m) : MOM_WIDTH'(m);
            hi = um >> (VALUE_WIDTH - FRAC_BITS);
            st_next[0].lane[l].neg  = m[MOM_WIDTH-1];
            st_next[0].lane[l].over = hi >= MOM_WIDTH'(in_data.side.rho[VALUE_WIDTH-2:0]);
            st_next[0].lane[l].rem  = st_next[0].lane[l].over ? '0 : hi[VALUE_WIDTH-1:0];
            st_next[0].lane[l].quo  = '0;
            st_next[0].lane[l].bits = {um[VALUE_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
        for (int i = 1; i <= DIV_STEPS; i++)
            st_next[i] = div_step(st_reg[i-1]);
    end

    // final rounding and limit
    always_comb
    begin
        dlane_t               s;
        logic                 rnd;
        logic [VALUE_WIDTH:0] q1;
        logic [VALUE_WIDTH:0] lim;
        val_t                 v [0:1];
        for (int l = 0; l < 2; l++)
        begin
            s   = st_reg[DIV_STEPS].lane[l];
            rnd = {s.rem, 1'b0} >= (VALUE_WIDTH+1)'(st_reg[DIV_STEPS].dvs);
            q1  = {1'b0, s.quo} + (VALUE_WIDTH+1)'(rnd);
            lim = {2'b00, {(VALUE_WIDTH-1){1'b1}}} + (VALUE_WIDTH+1)'(s.neg);
            if (s.over || (q1 > lim))
                q1 = lim;
            v[l] = s.neg ? val_t'(-q1) : val_t'(q1);
            if (!st_reg[DIV_STEPS].pos)
                v[l] = '0;
        end
        out_next.ux   = v[0];
        out_next.uy   = v[1];
        out_next.side = st_reg[DIV_STEPS].side;
    end

    assign out_valid = vld_reg[DIV_STEPS+1];
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STEPS] && st_reg[DIV_STEPS].pos && !st_reg[DIV_STEPS].lane[0].over
        |-> st_reg[DIV_STEPS].lane[0].rem < {1'b0, st_reg[DIV_STEPS].dvs})
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== sv/lbmc_eq.sv =====
// ----------------------------------------------------------------------------
// lbmc_eq
// Equilibrium and BGK relaxation pipeline: squares and weighted density,
// u^2, polynomial, feq, feq - f, omega product, saturated sum.
// ----------------------------------------------------------------------------
module lbmc_eq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  lbmc_pkg::rate_t   omega,
    input  logic              in_valid,
    input  lbmc_pkg::vel_t    in_data,
    output logic              out_valid,
    output lbmc_pkg::result_t out_data
);
    import lbmc_pkg::*;

    typedef logic [NDIR-1:0][PROD_WIDTH-1:0] prod_vec_t;

    typedef struct packed {
        prod_t psx, psy, psp, psm;
        prod_t prw0, prw1, prw2;
        logic  rw_neg;
        val_t  ux, uy;
        side_t side;
    } e1_t;

    typedef struct packed {
        val_t  sx, sy, sp, sm;
        val_t  rw0, rw1, rw2;
        val_t  ux, uy;
        side_t side;
    } e2_t;

    typedef struct packed {
        val_t  sx, sy, sp, sm, u2;
        val_t  rw0, rw1, rw2;
        val_t  ux, uy;
        side_t side;
    } e3_t;

    typedef struct packed {
        dist_t poly;
        val_t  rw0, rw1, rw2;
        val_t  ux, uy;
        side_t side;
    } e4_t;

    typedef struct packed {
        prod_vec_t       p;
        logic [NDIR-1:0] neg;
        val_t            ux, uy;
        side_t           side;
    } e5_t;

    typedef struct packed {
        dist_t feq;
        val_t  ux, uy;
        side_t side;
    } e6_t;

    typedef struct packed {
        logic [NDIR-1:0][VALUE_WIDTH:0] diff;
        val_t  ux, uy;
        side_t side;
    } e7_t;

    logic [8:0] vld_reg;
    e1_t     e1_reg, e1_next;
    e2_t     e2_reg, e2_next;
    e3_t     e3_reg, e3_next;
    e4_t     e4_reg, e4_next;
    e5_t     e5_reg, e5_next;
    e6_t     e6_reg, e6_next;
    e7_t     e7_reg, e7_next;
    e5_t     e8_reg, e8_next;
    result_t e9_reg, e9_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[7:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
            e3_reg <= e3_next;
            e4_reg <= e4_next;
            e5_reg <= e5_next;
            e6_reg <= e6_next;
            e7_reg <= e7_next;
            e8_reg <= e8_next;
            e9_reg <= e9_next;
        end
    end

    // squares of the velocity combinations and rho * weights
    always_comb
    begin
        logic [VALUE_WIDTH-1:0] ax, ay, ar;
        logic [CU_WIDTH-1:0]    ap, am;
        ax = mag_val(in_data.ux);
        ay = mag_val(in_data.uy);
        ar = mag_val(in_data.side.rho);
        ap = mag_cu(CU_WIDTH'(in_data.ux) + CU_WIDTH'(in_data.uy));
        am = mag_cu(CU_WIDTH'(in_data.ux) - CU_WIDTH'(in_data.uy));
        e1_next.psx    = prod_t'(ax) * prod_t'(ax);
        e1_next.psy    = prod_t'(ay) * prod_t'(ay);
        e1_next.psp    = prod_t'(ap) * prod_t'(ap);
        e1_next.psm    = prod_t'(am) * prod_t'(am);
        e1_next.prw0   = prod_t'(ar) * prod_t'(W_REST);
        e1_next.prw1   = prod_t'(ar) * prod_t'(W_AXIS);
        e1_next.prw2   = prod_t'(ar) * prod_t'(W_DIAG);
        e1_next.rw_neg = in_data.side.rho[VALUE_WIDTH-1];
        e1_next.ux     = in_data.ux;
        e1_next.uy     = in_data.uy;
        e1_next.side   = in_data.side;
    end

    always_comb
    begin
        e2_next.sx   = round_mag(e1_reg.psx, 1'b0);
        e2_next.sy   = round_mag(e1_reg.psy, 1'b0);
        e2_next.sp   = round_mag(e1_reg.psp, 1'b0);
        e2_next.sm   = round_mag(e1_reg.psm, 1'b0);
        e2_next.rw0  = round_mag(e1_reg.prw0, e1_reg.rw_neg);
        e2_next.rw1  = round_mag(e1_reg.prw1, e1_reg.rw_neg);
        e2_next.rw2  = round_mag(e1_reg.prw2, e1_reg.rw_neg);
        e2_next.ux   = e1_reg.ux;
        e2_next.uy   = e1_reg.uy;
        e2_next.side = e1_reg.side;
    end

    always_comb
    begin
        e3_next.sx   = e2_reg.sx;
        e3_next.sy   = e2_reg.sy;
        e3_next.sp   = e2_reg.sp;
        e3_next.sm   = e2_reg.sm;
        e3_next.u2   = sat_wide(PROD_WIDTH'(e2_reg.sx) + PROD_WIDTH'(e2_reg.sy));
        e3_next.rw0  = e2_reg.rw0;
        e3_next.rw1  = e2_reg.rw1;
        e3_next.rw2  = e2_reg.rw2;
        e3_next.ux   = e2_reg.ux;
        e3_next.uy   = e2_reg.uy;
        e3_next.side = e2_reg.side;
    end

    // poly = sat(round((2 + 6cu + 9cu^2 - 3u^2) / 2))
    always_comb
    begin
        logic signed [CU_WIDTH-1:0]   cp, cm, cu;
        val_t                         cu2;
        logic signed [POLY_WIDTH-1:0] pv, hv;
        logic [POLY_WIDTH-1:0]        mv, mh;
        cp = CU_WIDTH'(e3_reg.ux) + CU_WIDTH'(e3_reg.uy);
        cm = CU_WIDTH'(e3_reg.ux) - CU_WIDTH'(e3_reg.uy);
        for (int k = 0; k < NDIR; k++)
        begin
            unique case (k)
                1:       begin cu = CU_WIDTH'(e3_reg.ux);  cu2 = e3_reg.sx; end
                2:       begin cu = CU_WIDTH'(e3_reg.uy);  cu2 = e3_reg.sy; end
                3:       begin cu = -CU_WIDTH'(e3_reg.ux); cu2 = e3_reg.sx; end
                4:       begin cu = -CU_WIDTH'(e3_reg.uy); cu2 = e3_reg.sy; end
                5:       begin cu = cp;                    cu2 = e3_reg.sp; end
                6:       begin cu = -cm;                   cu2 = e3_reg.sm; end
                7:       begin cu = -cp;                   cu2 = e3_reg.sp; end
                8:       begin cu = cm;                    cu2 = e3_reg.sm; end
                default: begin cu = '0;                    cu2 = '0;        end
            endcase
            pv = POLY_BIAS
               + POLY_WIDTH'(cu) * POLY_WIDTH'(6)
               + POLY_WIDTH'(cu2) * POLY_WIDTH'(9)
               - POLY_WIDTH'(e3_reg.u2) * POLY_WIDTH'(3);
            mv = pv[POLY_WIDTH-1] ? POLY_WIDTH'(-pv) : POLY_WIDTH'(pv);
            mh = (mv + POLY_WIDTH'(1)) >> 1;
            hv = pv[POLY_WIDTH-1] ? $signed(-mh) : $signed(mh);
            e4_next.poly[k] = sat_wide(PROD_WIDTH'(hv));
        end
        e4_next.rw0  = e3_reg.rw0;
        e4_next.rw1  = e3_reg.rw1;
        e4_next.rw2  = e3_reg.rw2;
        e4_next.ux   = e3_reg.ux;
        e4_next.uy   = e3_reg.uy;
        e4_next.side = e3_reg.side;
    end

    always_comb
    begin
        val_t rw;
        val_t pk;
        for (int k = 0; k < NDIR; k++)
        begin
            if (k == 0)
                rw = e4_reg.rw0;
            else if (k < 5)
                rw = e4_reg.rw1;
            else
                rw = e4_reg.rw2;
            pk = $signed(e4_reg.poly[k]);
            e5_next.p[k]   = prod_t'(mag_val(rw)) * prod_t'(mag_val(pk));
            e5_next.neg[k] = rw[VALUE_WIDTH-1] ^ pk[VALUE_WIDTH-1];
        end
        e5_next.ux   = e4_reg.ux;
        e5_next.uy   = e4_reg.uy;
        e5_next.side = e4_reg.side;
    end

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
            e6_next.feq[k] = round_mag(e5_reg.p[k], e5_reg.neg[k]);
        e6_next.ux   = e5_reg.ux;
        e6_next.uy   = e5_reg.uy;
        e6_next.side = e5_reg.side;
    end

    always_comb
    begin
        for (int k = 0; k < NDIR; k++)
            e7_next.diff[k] = (VALUE_WIDTH+1)'($signed(e6_reg.feq[k]))
                            - (VALUE_WIDTH+1)'($signed(e6_reg.side.f[k]));
        e7_next.ux   = e6_reg.ux;
        e7_next.uy   = e6_reg.uy;
        e7_next.side = e6_reg.side;
    end

    always_comb
    begin
        logic signed [VALUE_WIDTH:0] d;
        for (int k = 0; k < NDIR; k++)
        begin
            d = $signed(e7_reg.diff[k]);
            e8_next.p[k]   = prod_t'(omega) * prod_t'(mag_cu(CU_WIDTH'(d)));
            e8_next.neg[k] = d[VALUE_WIDTH];
        end
        e8_next.ux   = e7_reg.ux;
        e8_next.uy   = e7_reg.uy;
        e8_next.side = e7_reg.side;
    end

    always_comb
    begin
        val_t t;
        for (int k = 0; k < NDIR; k++)
        begin
            t = round_mag(e8_reg.p[k], e8_reg.neg[k]);
            e9_next.f[k] = sat_wide(PROD_WIDTH'($signed(e8_reg.side.f[k])) + PROD_WIDTH'(t));
        end
        e9_next.rho = e8_reg.side.rho;
        e9_next.ux  = e8_reg.ux;
        e9_next.uy  = e8_reg.uy;
    end

    assign out_valid = vld_reg[8];
    assign out_data  = e9_reg;

endmodule

// ===== sv/lbm_d2q9_bgk_node_collide_core.sv =====
// ----------------------------------------------------------------------------
// lbm_d2q9_bgk_node_collide_core
// A node passes the front registers, the divider stages and the eq stages in turn.
// Throughput: one node per cycle; the 32-stage one-bit-per-stage divider and
// the multiplier stages are fully pipelined. A stalled result freezes all stages.
// Reset clears all valid bits; relax_rate returns to 1/0.9.
// ----------------------------------------------------------------------------
module lbm_d2q9_bgk_node_collide_core (
    input  logic          clk,
    input  logic          rst_n,
    lbmc_node_if.sink     node,
    lbmc_result_if.source result,
    lbmc_cfg_if.sink      cfg
);
    import lbmc_pkg::*;

    rate_t   rate_reg;
    logic    adv;
    logic    front_valid;
    front_t  front_data;
    logic    div_valid;
    vel_t    div_data;
    logic    res_valid;
    result_t res_data;
    dist_t   in_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= RATE_RESET;
        else if (cfg.valid)
            rate_reg <= cfg.relax_rate;
    end

    assign cfg.ready  = 1'b1;
    assign adv        = !res_valid || result.ready;
    assign node.ready = adv;

    assign in_dist = {node.dist_in_8, node.dist_in_7, node.dist_in_6,
                      node.dist_in_5, node.dist_in_4, node.dist_in_3,
                      node.dist_in_2, node.dist_in_1, node.dist_in_0};

    lbmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (node.valid),
        .in_dist   (in_dist),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    lbmc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    lbmc_eq u_eq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .omega     (rate_reg),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    assign result.valid      = res_valid;
    assign result.dist_out_0 = res_data.f[0];
    assign result.dist_out_1 = res_data.f[1];
    assign result.dist_out_2 = res_data.f[2];
    assign result.dist_out_3 = res_data.f[3];
    assign result.dist_out_4 = res_data.f[4];
    assign result.dist_out_5 = res_data.f[5];
    assign result.dist_out_6 = res_data.f[6];
    assign result.dist_out_7 = res_data.f[7];
    assign result.dist_out_8 = res_data.f[8];
    assign result.density    = res_data.rho;
    assign result.velocity_x = res_data.ux;
    assign result.velocity_y = res_data.uy;

`ifndef SYNTHESIS
    a_zero_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.rho[VALUE_WIDTH-1] || (res_data.rho == '0))
        |-> (res_data.ux == '0) && (res_data.uy == '0))
        else $error("nonzero velocity with non-positive density");
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid after reset");
`endif

endmodule

// ===== tb/lbmc_tb_if.sv =====
// ----------------------------------------------------------------------------
// lbmc_tb_if
// Testbench copy of the collision core channels is not needed: the RTL
// interfaces are used directly. This file holds the scoreboard result record.
// ----------------------------------------------------------------------------
package lbmc_tb_pkg;
    import lbmc_pkg::*;

    typedef struct {
        longint f[9];
        longint rho;
        longint ux;
        longint uy;
    } node_out_t;
endpackage

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the D2Q9 BGK collision core: random and corner-case nodes are sent
// with bursty valid and stalling ready, a scoreboard predicts each collided
// node in 64/128-bit integer arithmetic and compares every result field.
// ----------------------------------------------------------------------------
module testbench;
    import lbmc_pkg::*;
    import lbmc_tb_pkg::*;

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE = 64'sd1 << 28;
    localparam int LATENCY = 45;
    localparam int CFG_RELAX = 0;

    function automatic longint clamp(longint v);
        if (v > VMAX)
            return VMAX;
        if (v < VMIN)
            return VMIN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        logic neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a) * 128'(b);
        m = p < 0 ? -p : p;
        m = (m + (128'd1 << 27)) >> 28;
        if (a == 0 || b == 0)
            neg = 0;
        if (neg)
            return m > 128'd2147483648 ? VMIN : -longint'(m);
        return m > 128'd2147483647 ? VMAX : longint'(m);
    endfunction

    function automatic longint fx_div(longint num, longint den);
        logic [127:0] m;
        logic [127:0] q;
        logic [127:0] r;
        logic neg;
        neg = num < 0;
        m = num < 0 ? 128'(-num) : 128'(num);
        m = m << 28;
        q = m / 128'(den);
        r = m % 128'(den);
        if (2 * r >= 128'(den))
            q = q + 1;
        if (q == 0)
            neg = 0;
        if (neg)
            return q > 128'd2147483648 ? VMIN : -longint'(q);
        return q > 128'd2147483647 ? VMAX : longint'(q);
    endfunction

    function automatic longint half_away(longint v);
        longint m;
        m = ((v < 0 ? -v : v) + 1) >>> 1;
        return v < 0 ? -m : m;
    endfunction

    function automatic node_out_t collide(longint f[9], longint omega);
        node_out_t o;
        longint sum;
        longint mx;
        longint my;
        longint u2;
        longint cu;
        longint poly;
        longint wk;
        longint feq;
        int cx[9];
        int cy[9];
        cx = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
        cy = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
        sum = 0;
        for (int k = 0; k < 9; k++)
            sum += f[k];
        mx = f[1] + f[5] + f[8] - f[3] - f[6] - f[7];
        my = f[2] + f[5] + f[6] - f[4] - f[7] - f[8];
        o.rho = clamp(sum);
        o.ux = 0;
        o.uy = 0;
        if (o.rho > 0)
        begin
            o.ux = fx_div(mx, o.rho);
            o.uy = fx_div(my, o.rho);
        end
        u2 = clamp(fx_mul(o.ux, o.ux) + fx_mul(o.uy, o.uy));
        for (int k = 0; k < 9; k++)
        begin
            cu = cx[k] * o.ux + cy[k] * o.uy;
            poly = clamp(half_away(2 * ONE + 6 * cu + 9 * fx_mul(cu, cu) - 3 * u2));
            wk = k == 0 ? longint'(W_REST) : (k < 5 ? longint'(W_AXIS) : longint'(W_DIAG));
            feq = fx_mul(fx_mul(o.rho, wk), poly);
            o.f[k] = clamp(f[k] + fx_mul(omega, feq - f[k]));
        end
        return o;
    endfunction

    class collide_scoreboard;
        node_out_t pending[$];
        longint omega;
        int errors;

        function new();
            omega = longint'(RATE_RESET);
            errors = 0;
        endfunction

        function void note_node(longint f[9]);
            pending.push_back(collide(f, omega));
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(longint got[12]);
            node_out_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual density %0d",
                         $time, got[9]);
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 9; k++)
                check_field($sformatf("dist_out_%0d", k), e.f[k], got[k]);
            check_field("density", e.rho, got[9]);
            check_field("velocity_x", e.ux, got[10]);
            check_field("velocity_y", e.uy, got[11]);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    lbmc_node_if node ();
    lbmc_result_if result ();
    lbmc_cfg_if cfg ();
    collide_scoreboard sb;
    int stall_mode;

    lbm_d2q9_bgk_node_collide_core dut (
        .clk(clk), .rst_n(rst_n), .node(node.sink), .result(result.source), .cfg(cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        longint got[12];
        if (rst_n && result.valid && result.ready)
        begin
            got[0] = result.dist_out_0;
            got[1] = result.dist_out_1;
            got[2] = result.dist_out_2;
            got[3] = result.dist_out_3;
            got[4] = result.dist_out_4;
            got[5] = result.dist_out_5;
            got[6] = result.dist_out_6;
            got[7] = result.dist_out_7;
            got[8] = result.dist_out_8;
            got[9] = result.density;
            got[10] = result.velocity_x;
            got[11] = result.velocity_y;
            sb.check_result(got);
        end
    end

    always @(negedge clk)
    begin
        int ph;
        ph = $urandom_range(0, 15);
        case (stall_mode)
            0: result.ready <= 1'b1;
            1: result.ready <= ph < 11;
            default: result.ready <= ph < 3;
        endcase
    end

    task automatic put_node(longint f[9]);
        node.valid <= 1'b1;
        node.dist_in_0 <= f[0];
        node.dist_in_1 <= f[1];
        node.dist_in_2 <= f[2];
        node.dist_in_3 <= f[3];
        node.dist_in_4 <= f[4];
        node.dist_in_5 <= f[5];
        node.dist_in_6 <= f[6];
        node.dist_in_7 <= f[7];
        node.dist_in_8 <= f[8];
        do
            @(posedge clk);
        while (!node.ready);
        sb.note_node(f);
        @(negedge clk);
    endtask

    task automatic idle_node(int n);
        node.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        node.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_rate(longint rate);
        cfg.valid <= 1'b1;
        cfg.relax_rate <= rate_t'(rate);
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.omega = rate;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic longint rand_val(int style);
        case (style)
            0: return longint'(int'($urandom()));
            1: return longint'($urandom_range(0, 32'h2000_0000));
            2: return longint'($urandom_range(0, 32'h0800_0000)) - 64'sd16777216;
            default: return longint'($urandom_range(0, 32'h0200_0000));
        endcase
    endfunction

    initial
    begin
        #4000000;
        $display("lbm_d2q9_bgk_node_collide_core test failed");
        $finish;
    end

    initial
    begin
        longint f[9];
        longint rates[5];
        int style;
        sb = new();
        stall_mode = 0;
        rst_n = 1'b0;
        node.valid = 1'b0;
        cfg.valid = 1'b0;
        cfg.relax_rate = '0;
        result.ready = 1'b0;
        node.dist_in_0 = 0; node.dist_in_1 = 0; node.dist_in_2 = 0;
        node.dist_in_3 = 0; node.dist_in_4 = 0; node.dist_in_5 = 0;
        node.dist_in_6 = 0; node.dist_in_7 = 0; node.dist_in_8 = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset rate, corners, zero/negative density, overflow
        for (int k = 0; k < 9; k++) f[k] = ONE / 9;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = 0;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = VMAX;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = VMIN;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = -1;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = 0;
        f[1] = VMAX; f[0] = 1;
        put_node(f);
        f[1] = VMIN; f[0] = 1;
        put_node(f);
        for (int k = 0; k < 9; k++) f[k] = 0;
        f[2] = ONE; f[4] = 1;
        put_node(f);
        for (int d = 1; d < 9; d++)
        begin
            for (int k = 0; k < 9; k++) f[k] = ONE / 64;
            f[d] = ONE;
            put_node(f);
        end
        for (int k = 0; k < 9; k++) f[k] = (k % 2) ? VMAX : VMIN;
        put_node(f);
        drain();

        rates = '{0, 536870912, 1, 268435456, 1073741823};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                write_rate(ph == 5 ? longint'($urandom_range(0, 536870912)) : rates[ph - 1]);
            stall_mode = ph % 3;
            for (int i = 0; i < 225; i++)
            begin
                style = $urandom_range(0, 9);
                style = style < 2 ? 0 : (style < 5 ? 1 : (style < 7 ? 2 : 3));
                for (int k = 0; k < 9; k++) f[k] = rand_val(style);
                put_node(f);
                if ($urandom_range(0, 7) == 0)
                    idle_node($urandom_range(1, 12));
                if (i == 100)
                    drain();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("lbm_d2q9_bgk_node_collide_core test passed");
        else
            $display("lbm_d2q9_bgk_node_collide_core test failed");
        $finish;
    end
endmodule
